### design/rolling_variance_stationary_detector_macros.svh
// Assertion macros for the rolling variance stationary detector.
// Used by every RTL file that asserts; needs clk and rst_n in scope.
`ifndef ROLLING_VARIANCE_STATIONARY_DETECTOR_MACROS_SVH
`define ROLLING_VARIANCE_STATIONARY_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define RVSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RVSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RVSD_ASSERT(lbl, prop)
`define RVSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/rvsd_pkg.sv
// Shared widths, register indexes, control struct and helpers for the
// rolling variance stationary detector. No dependencies.
package rvsd_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int DATA_W     = 16;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int N_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = DATA_W + PTR_W + 1;
  localparam int SQ_W       = 2 * DATA_W + PTR_W - 1;
  localparam int NUM_W      = SQ_W + N_W - 1;
  localparam int DEN_W      = 2 * N_W;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int VAR_W      = 32;
  localparam int THR_W      = 32;
  localparam int WL_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STATIONARY_THRESHOLD = 1'b1;

  localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(5);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(838861);

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic upd_en;
  } win_ctl_t;

  function automatic logic [N_W-1:0] eff_len(input logic [WL_W-1:0] wl);
    logic [N_W-1:0] res;
    if (wl == '0) begin
      res = N_W'(1);
    end else if (32'(wl) > MAX_WINDOW) begin
      res = N_W'(MAX_WINDOW);
    end else begin
      res = N_W'(wl);
    end
    return res;
  endfunction

endpackage

### design/rvsd_win.sv
// Sample window: circular sample store, write pointer, fill flag and
// running sum / sum of squares. Depends on rvsd_pkg.
`include "rolling_variance_stationary_detector_macros.svh"
module rvsd_win (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rvsd_pkg::win_ctl_t                  ctl,
  input  logic [rvsd_pkg::N_W-1:0]            len,
  input  logic signed [rvsd_pkg::DATA_W-1:0]  sample,
  output logic signed [rvsd_pkg::SUM_W-1:0]   sum,
  output logic [rvsd_pkg::SQ_W-1:0]           sumsq,
  output logic [rvsd_pkg::N_W-1:0]            n
);
  import rvsd_pkg::*;

  logic signed [DATA_W-1:0] store [MAX_WINDOW];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]         wp_r, wp_nxt, wp_eff;
  logic                     full_r, full_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic [N_W-1:0]           wp_inc;
  logic signed [2*DATA_W-1:0] old_p, new_p;
  logic signed [SUM_W-1:0]  old_ext, new_ext;

  assign wp_eff  = (N_W'(wp_r) >= len) ? '0 : wp_r;
  assign wp_inc  = N_W'(wp_eff) + N_W'(1);
  assign old_p   = rd_data_r * rd_data_r;
  assign new_p   = sample * sample;
  assign old_ext = {{(SUM_W-DATA_W){rd_data_r[DATA_W-1]}}, rd_data_r};
  assign new_ext = {{(SUM_W-DATA_W){sample[DATA_W-1]}}, sample};

  always_comb begin
    sum_nxt = sum_r + new_ext;
    sq_nxt  = sq_r + SQ_W'($unsigned(new_p));
    if (full_r) begin
      sum_nxt = sum_nxt - old_ext;
      sq_nxt  = sq_nxt - SQ_W'($unsigned(old_p));
    end
    if (wp_inc >= len) begin
      wp_nxt   = '0;
      full_nxt = 1'b1;
    end else begin
      wp_nxt   = wp_inc[PTR_W-1:0];
      full_nxt = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      wp_r   <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (ctl.upd_en) begin
      wp_r   <= wp_nxt;
      full_r <= full_nxt;
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= store[wp_eff];
    end
    if (ctl.upd_en) begin
      store[wp_eff] <= sample;
    end
  end

  assign sum   = sum_r;
  assign sumsq = sq_r;
  assign n     = full_r ? len : N_W'(wp_r);

  `RVSD_ASSERT_NEXT(a_clear_empties, ctl.clear, wp_r == '0 && !full_r && sum_r == '0 && sq_r == '0)
  `RVSD_ASSERT(a_ptr_in_window, N_W'(wp_r) < len)
  `RVSD_ASSERT(a_ctl_exclusive, !(ctl.rd_en && ctl.upd_en))

endmodule

### design/rvsd_div.sv
// Restoring divider, one quotient bit per cycle, shared by every item.
// Depends on rvsd_pkg.
`include "rolling_variance_stationary_detector_macros.svh"
module rvsd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rvsd_pkg::NUM_W-1:0]  dividend,
  input  logic [rvsd_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [rvsd_pkg::NUM_W-1:0]  quotient
);
  import rvsd_pkg::*;

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] dvs_r;
  logic [DEN_W:0]   rem_r, rem_sh;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, fit;

  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      busy_r <= cnt_r != CNT_W'(1);
      done_r <= cnt_r == CNT_W'(1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fit};
      rem_r <= fit ? rem_sh - {1'b0, dvs_r} : rem_sh;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `RVSD_ASSERT(a_busy_counts, !busy_r || cnt_r != '0)
  `RVSD_ASSERT(a_done_idle, !done_r || !busy_r)
  `RVSD_ASSERT(a_start_idle, !start || !busy_r)

endmodule

### design/rolling_variance_stationary_detector.sv
// Rolling window variance with stationary flag; top level and sequencer.
// Sequence per transaction: S_UPD, S_MUL_A, S_MUL_B, S_SUB, S_DIV, S_OUT; S_DIV
// runs the 39-step shared divider and is skipped when fewer than two samples are
// held or the spread is zero. Input stalls until the result is taken.
// Reset (rst_n low, synchronous) empties the window, length 5, threshold 838861.
// Depends on rvsd_pkg, rvsd_win, rvsd_div and the macros header.
`include "rolling_variance_stationary_detector_macros.svh"
module rolling_variance_stationary_detector (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [rvsd_pkg::DATA_W-1:0]      in_sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [rvsd_pkg::VAR_W-1:0]              out_variance,
  output logic                                    out_stationary,
  output logic [rvsd_pkg::N_W-1:0]                out_samples_held,
  input  logic                                    cfg_we,
  input  logic [rvsd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rvsd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import rvsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_MUL_A, S_MUL_B, S_SUB, S_DIV, S_OUT
  } state_t;

  state_t                  state_r;
  logic [WL_W-1:0]         wl_r;
  logic [THR_W-1:0]        thr_r;
  logic signed [DATA_W-1:0] sample_r;
  logic signed [NUM_W:0]   prod_a_r, prod_b_r, num;
  logic [VAR_W-1:0]        var_r;
  logic [N_W-1:0]          n_r, len, n;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic signed [SQ_W:0]    mul_x;
  logic signed [SUM_W:0]   mul_y;
  logic signed [SQ_W+SUM_W+1:0] mul_p;
  logic [DEN_W-1:0]        den;
  logic                    accept, div_start, div_done, num_pos;
  logic [NUM_W-1:0]        quotient;
  win_ctl_t                wctl;

  assign len    = eff_len(wl_r);
  assign accept = in_valid && !in_stall;

  assign wctl.clear  = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
  assign wctl.rd_en  = accept;
  assign wctl.upd_en = (state_r == S_UPD);

  rvsd_win u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (wctl),
    .len    (len),
    .sample (sample_r),
    .sum    (sum),
    .sumsq  (sumsq),
    .n      (n)
  );

  // one multiplier, used for n*sumsq then sum*sum
  always_comb begin
    if (state_r == S_MUL_A) begin
      mul_x = $signed({1'b0, sumsq});
      mul_y = $signed({{(SUM_W+1-N_W){1'b0}}, n});
    end else begin
      mul_x = {{(SQ_W+1-SUM_W){sum[SUM_W-1]}}, sum};
      mul_y = {sum[SUM_W-1], sum};
    end
  end
  assign mul_p = mul_x * mul_y;

  assign num       = prod_a_r - prod_b_r;
  assign num_pos   = !num[NUM_W] && (num != '0);
  assign den       = n_r * (n_r - N_W'(1));
  assign div_start = (state_r == S_SUB) && (n_r >= N_W'(2)) && num_pos;

  rvsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num[NUM_W-1:0]),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= WL_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:        wl_r  <= cfg_data[WL_W-1:0];
        REG_STATIONARY_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sample_r <= in_sample;
            state_r  <= S_UPD;
          end
        end
        S_UPD: state_r <= S_MUL_A;
        S_MUL_A: begin
          prod_a_r <= mul_p[NUM_W:0];
          n_r      <= n;
          state_r  <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_b_r <= mul_p[NUM_W:0];
          state_r  <= S_SUB;
        end
        S_SUB: begin
          if (div_start) begin
            state_r <= S_DIV;
          end else begin
            var_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            var_r   <= (|quotient[NUM_W-1:VAR_W]) ? '1 : quotient[VAR_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_variance     = var_r;
  assign out_stationary   = var_r < thr_r;
  assign out_samples_held = n_r;

  `RVSD_ASSERT(a_one_item, !(out_valid && !in_stall))
  `RVSD_ASSERT_NEXT(a_div_to_out, state_r == S_DIV && div_done, state_r == S_OUT)
  `RVSD_ASSERT(a_short_window_zero, !(out_valid && out_samples_held < N_W'(2)) || out_variance == '0)

endmodule
